// ===== rtl/iepq_pkg.sv =====
package iepq_pkg;

	// fixed field widths of the item ports
	localparam int ID_W       = 6;
	localparam int REQ_PRIO_W = 32;

	// input opcodes
	localparam logic OP_SET  = 1'b0;
	localparam logic OP_POLL = 1'b1;

	// command broadcast to every cell of the sorted chain
	typedef enum logic [1:0] {
		CH_HOLD   = 2'd0,
		CH_REMOVE = 2'd1,
		CH_INSERT = 2'd2,
		CH_POP    = 2'd3
	} chain_op_t;

	typedef struct packed {
		chain_op_t         op;
		logic [ID_W-1:0]   key_id;
	} cell_cmd_t;

	// top level sequencer, one-hot
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_REMOVE = 3'b010,
		ST_INSERT = 3'b100
	} ctrl_state_t;

endpackage

// ===== rtl/iepq_cell.sv =====
module iepq_cell #(
	parameter int PRIORITY_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iepq_pkg::cell_cmd_t           cmd,
	input  logic [PRIORITY_BITS-1:0]      key_prio,
	// neighbor toward the head
	input  logic                          up_valid,
	input  logic [iepq_pkg::ID_W-1:0]     up_id,
	input  logic [PRIORITY_BITS-1:0]      up_prio,
	input  logic                          up_before,
	// neighbor toward the tail
	input  logic                          dn_valid,
	input  logic [iepq_pkg::ID_W-1:0]     dn_id,
	input  logic [PRIORITY_BITS-1:0]      dn_prio,
	// own entry
	output logic                          valid,
	output logic [iepq_pkg::ID_W-1:0]     id,
	output logic [PRIORITY_BITS-1:0]      prio,
	output logic                          ahead
);

	logic                          valid_q;
	logic [iepq_pkg::ID_W-1:0]     id_q;
	logic [PRIORITY_BITS-1:0]      prio_q;
	logic                          valid_nxt;
	logic [iepq_pkg::ID_W-1:0]     id_nxt;
	logic [PRIORITY_BITS-1:0]      prio_nxt;
	logic                          match;
	logic                          key_before;

	always_comb begin
		match      = valid_q && (id_q == cmd.key_id);
		// key ranks ahead of this entry: higher priority, tie to smaller id
		key_before = !valid_q || (key_prio > prio_q) ||
			((key_prio == prio_q) && (cmd.key_id < id_q));
		valid_nxt  = valid_q;
		id_nxt     = id_q;
		prio_nxt   = prio_q;
		case (cmd.op)
			iepq_pkg::CH_REMOVE: begin
				// entries at or behind the removed key close the gap
				if (key_before || match) begin
					valid_nxt = dn_valid;
					id_nxt    = dn_id;
					prio_nxt  = dn_prio;
				end
			end
			iepq_pkg::CH_INSERT: begin
				if (key_before) begin
					if (up_before) begin
						valid_nxt = up_valid;
						id_nxt    = up_id;
						prio_nxt  = up_prio;
					end else begin
						valid_nxt = 1'b1;
						id_nxt    = cmd.key_id;
						prio_nxt  = key_prio;
					end
				end
			end
			iepq_pkg::CH_POP: begin
				valid_nxt = dn_valid;
				id_nxt    = dn_id;
				prio_nxt  = dn_prio;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_nxt;
		end
	end

	always_ff @(posedge clk) begin
		id_q   <= id_nxt;
		prio_q <= prio_nxt;
	end

	assign valid = valid_q;
	assign id    = id_q;
	assign prio  = prio_q;
	assign ahead = key_before;

endmodule

// ===== rtl/indexed_event_priority_queue_top.sv =====
// indexed event priority queue
// input channel (in_valid/in_ready) carries opcode, event_id, priority_req;
// output channel (out_valid/out_ready) carries found, polled_id.
// a set transfer writes an event's priority and marks it pending, producing
// no result; a poll transfer removes the pending event with the highest
// priority (ties to the smallest id) and yields one result, found = 0 and
// polled_id = 0 when nothing is pending.
// pending events sit in a chain of cells kept sorted by priority; the head
// cell is always the next poll answer. a poll shifts the chain one place in
// the transfer cycle and its result is registered, visible in the cycle after.
// a set on an absent event reads the priority store, then does one insert
// shift of the chain; a set on a pending event first has its old entry
// removed by a shift using the stored old priority, then is inserted.
// a set with an id beyond the table changes nothing.
// in_ready is low while a set is working through the chain and while a poll
// result waits in the output register with out_ready low; a set never
// produces a result, yet a stalled receiver holds back sets as well as polls.
// reset clears all pending marks and empties the chain; the priority store
// holds no reset value and its read value is only used for pending events.
module indexed_event_priority_queue_top #(
	parameter int MAX_EVENTS    = 64,
	parameter int PRIORITY_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [iepq_pkg::ID_W-1:0]         event_id,
	input  logic [iepq_pkg::REQ_PRIO_W-1:0]   priority_req,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [iepq_pkg::ID_W-1:0]         polled_id
);

	// only ids reachable through the id field can ever be pending
	localparam int ID_SPAN = 1 << iepq_pkg::ID_W;
	localparam int NUM_IDS = (MAX_EVENTS < ID_SPAN) ? MAX_EVENTS : ID_SPAN;
	localparam int IDX_W   = $clog2(NUM_IDS);

	iepq_pkg::ctrl_state_t            state_q;
	logic [iepq_pkg::ID_W-1:0]        req_id_q;
	logic [PRIORITY_BITS-1:0]         req_prio_q;
	logic [PRIORITY_BITS-1:0]         old_prio_q;
	logic [NUM_IDS-1:0]               pending_q;
	logic [PRIORITY_BITS-1:0]         prio_mem [NUM_IDS];
	logic                             out_valid_q;
	logic                             found_q;
	logic [iepq_pkg::ID_W-1:0]        polled_id_q;

	logic                             in_xfer;
	logic                             set_xfer;
	logic                             poll_xfer;
	logic                             id_ok;
	logic [IDX_W-1:0]                 req_idx;
	logic [PRIORITY_BITS-1:0]         new_prio;
	iepq_pkg::cell_cmd_t              cmd;
	logic [PRIORITY_BITS-1:0]         key_prio;

	// chain taps, one extra invalid slot past the tail
	logic                             c_valid  [NUM_IDS+1];
	logic [iepq_pkg::ID_W-1:0]        c_id     [NUM_IDS+1];
	logic [PRIORITY_BITS-1:0]         c_prio   [NUM_IDS+1];
	logic                             c_before [NUM_IDS];

	// priority kept in its low PRIORITY_BITS bits, zero extended if wider
	generate
		if (PRIORITY_BITS <= iepq_pkg::REQ_PRIO_W) begin : g_prio_trunc
			assign new_prio = priority_req[PRIORITY_BITS-1:0];
		end else begin : g_prio_ext
			assign new_prio = {{(PRIORITY_BITS-iepq_pkg::REQ_PRIO_W){1'b0}}, priority_req};
		end
	endgenerate

	assign id_ok   = int'(event_id) < NUM_IDS;
	assign req_idx = event_id[IDX_W-1:0];

	// a poll needs the output register free, or freed this cycle
	assign in_ready  = (state_q == iepq_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign in_xfer   = in_valid && in_ready;
	assign set_xfer  = in_xfer && (opcode == iepq_pkg::OP_SET);
	assign poll_xfer = in_xfer && (opcode == iepq_pkg::OP_POLL);

	// chain command: pop on poll, remove old entry, then insert the new one
	always_comb begin
		cmd.op     = iepq_pkg::CH_HOLD;
		cmd.key_id = req_id_q;
		key_prio   = req_prio_q;
		case (state_q)
			iepq_pkg::ST_IDLE: begin
				if (poll_xfer) begin
					cmd.op = iepq_pkg::CH_POP;
				end
			end
			iepq_pkg::ST_REMOVE: begin
				cmd.op   = iepq_pkg::CH_REMOVE;
				key_prio = old_prio_q;
			end
			iepq_pkg::ST_INSERT: begin
				cmd.op = iepq_pkg::CH_INSERT;
			end
			default: begin
			end
		endcase
	end

	// sequencer and pending marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= iepq_pkg::ST_IDLE;
			pending_q <= '0;
		end else begin
			case (state_q)
				iepq_pkg::ST_IDLE: begin
					if (set_xfer && id_ok) begin
						pending_q[req_idx] <= 1'b1;
						state_q <= pending_q[req_idx] ? iepq_pkg::ST_REMOVE
							: iepq_pkg::ST_INSERT;
					end else if (poll_xfer && c_valid[0]) begin
						pending_q[c_id[0][IDX_W-1:0]] <= 1'b0;
					end
				end
				iepq_pkg::ST_REMOVE: state_q <= iepq_pkg::ST_INSERT;
				iepq_pkg::ST_INSERT: state_q <= iepq_pkg::ST_IDLE;
				default:             state_q <= iepq_pkg::ST_IDLE;
			endcase
		end
	end

	// priority store: old value read out as the new one is written
	always_ff @(posedge clk) begin
		if (set_xfer && id_ok) begin
			old_prio_q        <= prio_mem[req_idx];
			prio_mem[req_idx] <= new_prio;
			req_id_q          <= event_id;
			req_prio_q        <= new_prio;
		end
	end

	// poll result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (poll_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_xfer) begin
			found_q     <= c_valid[0];
			polled_id_q <= c_valid[0] ? c_id[0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign polled_id = polled_id_q;

	// sorted chain, head at index 0
	assign c_valid[NUM_IDS] = 1'b0;
	assign c_id[NUM_IDS]    = '0;
	assign c_prio[NUM_IDS]  = '0;

	generate
		for (genvar i = 0; i < NUM_IDS; i++) begin : g_cell
			logic                         up_valid;
			logic [iepq_pkg::ID_W-1:0]    up_id;
			logic [PRIORITY_BITS-1:0]     up_prio;
			logic                         up_before;

			if (i == 0) begin : g_head
				assign up_valid  = 1'b0;
				assign up_id     = '0;
				assign up_prio   = '0;
				assign up_before = 1'b0;
			end else begin : g_body
				assign up_valid  = c_valid[i-1];
				assign up_id     = c_id[i-1];
				assign up_prio   = c_prio[i-1];
				assign up_before = c_before[i-1];
			end

			iepq_cell #(
				.PRIORITY_BITS (PRIORITY_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.key_prio  (key_prio),
				.up_valid  (up_valid),
				.up_id     (up_id),
				.up_prio   (up_prio),
				.up_before (up_before),
				.dn_valid  (c_valid[i+1]),
				.dn_id     (c_id[i+1]),
				.dn_prio   (c_prio[i+1]),
				.valid     (c_valid[i]),
				.id        (c_id[i]),
				.prio      (c_prio[i]),
				.ahead     (c_before[i])
			);
		end
	endgenerate

endmodule
